### sv/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared types, widths and the root saturation function.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W  = 16;
  localparam int ROOT_W  = 32;
  localparam int ROOT_FB = 16;
  localparam int DELTA_W = 2 * COEF_W + 2;
  localparam int SQRT_W  = COEF_W + 1;
  localparam int SREM_W  = SQRT_W + 1;
  localparam int SQRT_N  = DELTA_W / 2;
  localparam int NUM_W   = COEF_W + 2;
  localparam int DEN_W   = COEF_W + 1;
  localparam int QUO_W   = DEN_W + ROOT_FB;
  localparam int DIV_N   = QUO_W;
  localparam int LAT     = SQRT_N + DIV_N + 4;

  typedef enum logic [1:0] {
    KIND_LINEAR = 2'd0,
    KIND_NONE   = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_TWO    = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } req_t;

  typedef struct packed {
    kind_e                    root_kind;
    logic signed [ROOT_W-1:0] root_plus;
    logic signed [ROOT_W-1:0] root_minus;
    logic                     saturated;
  } rsp_t;

  typedef struct packed {
    kind_e                    kind;
    logic                     a_neg;
    logic signed [COEF_W-1:0] b;
    logic [DEN_W-1:0]         den;
    logic                     neg_p;
    logic                     neg_m;
  } ctx_t;

  typedef struct packed {
    logic              sat;
    logic [ROOT_W-1:0] val;
  } root_t;

  function automatic root_t sat_root(input logic [QUO_W-1:0] q, input logic neg);
    root_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (q > QUO_W'(33'h080000000)) begin
        r.sat = 1'b1;
        r.val = 32'h80000000;
      end else begin
        r.val = ROOT_W'(0) - q[ROOT_W-1:0];
      end
    end else begin
      if (q > QUO_W'(33'h07FFFFFFF)) begin
        r.sat = 1'b1;
        r.val = 32'h7FFFFFFF;
      end else begin
        r.val = q[ROOT_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

### sv/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit from two radicand bits per clock, restoring form.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  logic                             clk_i,
  input  logic [qrs_pkg::DELTA_W-1:0]      rad_i,
  input  logic [qrs_pkg::SREM_W-1:0]       rem_i,
  input  logic [qrs_pkg::SQRT_W-1:0]       root_i,
  output logic [qrs_pkg::DELTA_W-1:0]      rad_o,
  output logic [qrs_pkg::SREM_W-1:0]       rem_o,
  output logic [qrs_pkg::SQRT_W-1:0]       root_o
);

  logic [qrs_pkg::SREM_W+1:0]  cur;
  logic [qrs_pkg::SREM_W+1:0]  trial;
  logic [qrs_pkg::SREM_W+1:0]  diff;
  logic                        ge;
  logic [qrs_pkg::DELTA_W-1:0] rad_d, rad_q;
  logic [qrs_pkg::SREM_W-1:0]  rem_d, rem_q;
  logic [qrs_pkg::SQRT_W-1:0]  root_d, root_q;

  always_comb begin
    cur    = {rem_i, rad_i[qrs_pkg::DELTA_W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = cur - trial;
    ge     = cur >= trial;
    rem_d  = ge ? diff[qrs_pkg::SREM_W-1:0] : cur[qrs_pkg::SREM_W-1:0];
    root_d = {root_i[qrs_pkg::SQRT_W-2:0], ge};
    rad_d  = {rad_i[qrs_pkg::DELTA_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

### sv/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit per clock by restoring long division.
// ----------------------------------------------------------------------------
module qrs_div_cell (
  input  logic                       clk_i,
  input  logic [qrs_pkg::DEN_W-1:0]  den_i,
  input  logic [qrs_pkg::DEN_W-1:0]  rem_i,
  input  logic [qrs_pkg::QUO_W-1:0]  dq_i,
  output logic [qrs_pkg::DEN_W-1:0]  rem_o,
  output logic [qrs_pkg::QUO_W-1:0]  dq_o
);

  logic [qrs_pkg::DEN_W:0]   cur;
  logic [qrs_pkg::DEN_W:0]   diff;
  logic                      ge;
  logic [qrs_pkg::DEN_W-1:0] rem_d, rem_q;
  logic [qrs_pkg::QUO_W-1:0] dq_d, dq_q;

  always_comb begin
    cur   = {rem_i, dq_i[qrs_pkg::QUO_W-1]};
    diff  = cur - {1'b0, den_i};
    ge    = cur >= {1'b0, den_i};
    rem_d = ge ? diff[qrs_pkg::DEN_W-1:0] : cur[qrs_pkg::DEN_W-1:0];
    dq_d  = {dq_i[qrs_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign rem_o = rem_q;
  assign dq_o  = dq_q;

endmodule

### sv/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c in Q16.16 through a square root cell row
// and two divider cell rows.
// ----------------------------------------------------------------------------
// Channel   Ports                      Direction  Meaning
// request   start, busy, req_i         in         coefficient set
// result    done_o, result_o           out        root kind, roots, flag
//
// A request is taken every cycle; busy is always low.
// Each result is on the outputs in request order.
// The datapath has 17 square root cells and 33 divider cells per lane.
// Reset clears only the valid pipeline; results are never stalled.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qrs_pkg::req_t req_i,
  output logic          done_o,
  output qrs_pkg::rsp_t result_o
);

  localparam int W   = qrs_pkg::COEF_W;
  localparam int SN  = qrs_pkg::SQRT_N;
  localparam int DN  = qrs_pkg::DIV_N;
  localparam int PL  = SN + DN + 2;

  logic                        accept;
  logic [W:0]                  ma, mb, mc;
  logic [2*W+1:0]              pb, pac;

  logic                        v1_q;
  logic [qrs_pkg::DELTA_W-1:0] b2_q, ac4_q;
  logic                        ac_neg_q, a_zero_q, a_neg_q;
  logic signed [W-1:0]         b_q;
  logic [qrs_pkg::DEN_W-1:0]   den_q;

  logic [qrs_pkg::DELTA_W-1:0] sum, diff, delta;
  logic                        delta_neg;
  qrs_pkg::ctx_t               ctx2;

  logic [PL-1:0]               v_q;
  qrs_pkg::ctx_t               ctx_q [PL];
  logic [qrs_pkg::DELTA_W-1:0] delta_q;

  logic [qrs_pkg::DELTA_W-1:0] rad_s  [SN+1];
  logic [qrs_pkg::SREM_W-1:0]  rem_s  [SN+1];
  logic [qrs_pkg::SQRT_W-1:0]  root_s [SN+1];

  logic signed [qrs_pkg::NUM_W-1:0] neg_b, np, nm;
  logic [qrs_pkg::NUM_W-1:0]   mp, mm;
  qrs_pkg::ctx_t               ctx_s;

  logic [qrs_pkg::DEN_W-1:0]   rem_p [DN+1];
  logic [qrs_pkg::DEN_W-1:0]   rem_m [DN+1];
  logic [qrs_pkg::QUO_W-1:0]   dq_p  [DN+1];
  logic [qrs_pkg::QUO_W-1:0]   dq_m  [DN+1];

  qrs_pkg::root_t              rp, rm;
  qrs_pkg::ctx_t               ctx_l;
  logic                        done_q;
  qrs_pkg::rsp_t               res_d, res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ma  = req_i.coef_a[W-1] ? (W+1)'(~{1'b1, req_i.coef_a} + 1'b1) : {1'b0, req_i.coef_a};
    mb  = req_i.coef_b[W-1] ? (W+1)'(~{1'b1, req_i.coef_b} + 1'b1) : {1'b0, req_i.coef_b};
    mc  = req_i.coef_c[W-1] ? (W+1)'(~{1'b1, req_i.coef_c} + 1'b1) : {1'b0, req_i.coef_c};
    pb  = mb * mb;
    pac = ma * mc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_q     <= pb;
    ac4_q    <= {pac[qrs_pkg::DELTA_W-3:0], 2'b00};
    ac_neg_q <= (req_i.coef_a[W-1] != req_i.coef_c[W-1]) && (req_i.coef_c != '0);
    a_zero_q <= req_i.coef_a == '0;
    a_neg_q  <= req_i.coef_a[W-1];
    b_q      <= req_i.coef_b;
    den_q    <= {ma[W-1:0], 1'b0};
  end

  always_comb begin
    sum       = b2_q + ac4_q;
    diff      = b2_q - ac4_q;
    delta_neg = !ac_neg_q && (b2_q < ac4_q);
    delta     = ac_neg_q ? sum : diff;
    ctx2      = '0;
    ctx2.a_neg = a_neg_q;
    ctx2.b     = b_q;
    ctx2.den   = den_q;
    if (a_zero_q) begin
      ctx2.kind = qrs_pkg::KIND_LINEAR;
    end else if (delta_neg) begin
      ctx2.kind = qrs_pkg::KIND_NONE;
    end else if (delta == '0) begin
      ctx2.kind = qrs_pkg::KIND_DOUBLE;
    end else begin
      ctx2.kind = qrs_pkg::KIND_TWO;
    end
  end

  always_comb begin
    neg_b = -$signed({{2{ctx_q[SN].b[W-1]}}, ctx_q[SN].b});
    np    = neg_b + $signed({1'b0, root_s[SN]});
    nm    = neg_b - $signed({1'b0, root_s[SN]});
    mp    = np[qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-np) : qrs_pkg::NUM_W'(np);
    mm    = nm[qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-nm) : qrs_pkg::NUM_W'(nm);
    ctx_s       = ctx_q[SN];
    ctx_s.neg_p = np[qrs_pkg::NUM_W-1] ^ ctx_q[SN].a_neg;
    ctx_s.neg_m = nm[qrs_pkg::NUM_W-1] ^ ctx_q[SN].a_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PL-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= (ctx2.kind == qrs_pkg::KIND_TWO) ? delta : '0;
    ctx_q[0] <= ctx2;
    for (int i = 1; i < PL; i++) begin
      ctx_q[i] <= (i == SN + 1) ? ctx_s : ctx_q[i-1];
    end
    dq_p[0] <= {mp[qrs_pkg::DEN_W-1:0], qrs_pkg::ROOT_FB'(0)};
    dq_m[0] <= {mm[qrs_pkg::DEN_W-1:0], qrs_pkg::ROOT_FB'(0)};
  end

  assign rad_s[0]  = delta_q;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rem_p[0]  = '0;
  assign rem_m[0]  = '0;

  for (genvar g = 0; g < SN; g++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (rad_s[g]),
      .rem_i  (rem_s[g]),
      .root_i (root_s[g]),
      .rad_o  (rad_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .root_o (root_s[g+1])
    );
  end

  for (genvar g = 0; g < DN; g++) begin : g_div
    qrs_div_cell u_plus (
      .clk_i (clk_i),
      .den_i (ctx_q[SN+1+g].den),
      .rem_i (rem_p[g]),
      .dq_i  (dq_p[g]),
      .rem_o (rem_p[g+1]),
      .dq_o  (dq_p[g+1])
    );
    qrs_div_cell u_minus (
      .clk_i (clk_i),
      .den_i (ctx_q[SN+1+g].den),
      .rem_i (rem_m[g]),
      .dq_i  (dq_m[g]),
      .rem_o (rem_m[g+1]),
      .dq_o  (dq_m[g+1])
    );
  end

  always_comb begin
    ctx_l = ctx_q[PL-1];
    rp    = qrs_pkg::sat_root(dq_p[DN], ctx_l.neg_p);
    rm    = qrs_pkg::sat_root(dq_m[DN], ctx_l.neg_m);
    res_d = '0;
    res_d.root_kind = ctx_l.kind;
    if (ctx_l.kind == qrs_pkg::KIND_DOUBLE) begin
      res_d.root_plus = rp.val;
      res_d.saturated = rp.sat;
    end else if (ctx_l.kind == qrs_pkg::KIND_TWO) begin
      res_d.root_plus  = rp.val;
      res_d.root_minus = rm.val;
      res_d.saturated  = rp.sat || rm.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.root_kind == qrs_pkg::KIND_LINEAR ||
               result_o.root_kind == qrs_pkg::KIND_NONE)
    |-> (result_o.root_plus == '0 && result_o.root_minus == '0 && !result_o.saturated))
    else $error("unused roots not zero");

  a_double_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.root_kind == qrs_pkg::KIND_DOUBLE |-> result_o.root_minus == '0)
    else $error("double root with second root set");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.saturated
    |-> (result_o.root_plus == 32'sh7FFFFFFF || result_o.root_plus == 32'sh80000000 ||
         result_o.root_minus == 32'sh7FFFFFFF || result_o.root_minus == 32'sh80000000))
    else $error("saturation flag without clipped root");

endmodule

### tb/quadratic_root_solver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient sets through the request channel with random gaps,
// predicts root kind, both Q16.16 roots and the saturation flag with an
// exact integer model, and compares every result against it in order.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top_tb;

  localparam int PIPE_LAT   = qrs_pkg::LAT;
  localparam int IDLE_LIMIT = 2000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  qrs_pkg::req_t  req_i;
  logic           done_o;
  qrs_pkg::rsp_t  result_o;

  quadratic_root_solver_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  qrs_pkg::req_t pending_reqs[$];
  int            gap_q[$];
  qrs_pkg::rsp_t expected_roots[$];
  int            mismatches;
  int            idle_cycles;
  int            gap_left;
  bit            stim_done;
  bit            hold_off;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] clip_root(longint num, longint den, inout logic sat);
    longint unsigned q;
    longint unsigned n;
    longint unsigned d;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << 16) / d;
    neg = (num < 0) != (den < 0);
    if (neg) begin
      if (q > 64'h80000000) begin
        q = 64'h80000000;
        sat = 1'b1;
      end
      return 32'(-longint'(q));
    end
    if (q > 64'h7FFFFFFF) begin
      q = 64'h7FFFFFFF;
      sat = 1'b1;
    end
    return 32'(q);
  endfunction

  function automatic qrs_pkg::rsp_t solve_roots(qrs_pkg::req_t r);
    qrs_pkg::rsp_t o;
    longint a;
    longint b;
    longint c;
    longint delta;
    longint s;
    o = '0;
    a = r.coef_a;
    b = r.coef_b;
    c = r.coef_c;
    if (a == 0) begin
      o.root_kind = qrs_pkg::KIND_LINEAR;
      return o;
    end
    delta = b * b - 4 * a * c;
    if (delta < 0) begin
      o.root_kind = qrs_pkg::KIND_NONE;
    end else if (delta == 0) begin
      o.root_kind = qrs_pkg::KIND_DOUBLE;
      o.root_plus = clip_root(-b, 2 * a, o.saturated);
    end else begin
      s = 0;
      for (int k = 20; k >= 0; k--) begin
        if ((s | (64'sd1 << k)) * (s | (64'sd1 << k)) <= delta) s = s | (64'sd1 << k);
      end
      o.root_kind  = qrs_pkg::KIND_TWO;
      o.root_plus  = clip_root(-b + s, 2 * a, o.saturated);
      o.root_minus = clip_root(-b - s, 2 * a, o.saturated);
    end
    return o;
  endfunction

  task automatic add_req(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    qrs_pkg::req_t r;
    r.coef_a = a;
    r.coef_b = b;
    r.coef_c = c;
    pending_reqs.push_back(r);
    gap_q.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
  endtask

  initial begin
    logic [15:0] a;
    logic [15:0] r;
    logic [15:0] c;
    stim_done = 1'b0;
    add_req(16'h0000, 16'h1234, 16'h0100);
    add_req(16'h0100, 16'h0000, 16'h0100);
    add_req(16'h0100, 16'hFE00, 16'h0100);
    add_req(16'h0100, 16'h0000, 16'hFF00);
    add_req(16'h0001, 16'h7FFF, 16'h0000);
    add_req(16'h0001, 16'h8000, 16'h7FFF);
    add_req(16'hFFFF, 16'h8000, 16'h8000);
    add_req(16'h8000, 16'h7FFF, 16'h7FFF);
    add_req(16'h7FFF, 16'h8000, 16'h8000);
    add_req(16'h8000, 16'h8000, 16'h8000);
    add_req(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_req(16'h0004, 16'h0001, 16'h0000);
    add_req(16'h0001, 16'h0003, 16'h0002);
    add_req(16'h0001, 16'h0002, 16'h0001);
    add_req(16'hFFFF, 16'h0002, 16'hFFFF);
    add_req(16'h0001, 16'hFFFF, 16'h8000);
    add_req(16'hFFFF, 16'h0000, 16'h7FFF);
    add_req(16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 1650; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          a = 16'($urandom_range(1, 255) * (($urandom_range(0, 1) != 0) ? -1 : 1));
          r = 16'($urandom_range(0, 127) * (($urandom_range(0, 1) != 0) ? -1 : 1));
          add_req(a, 16'(2 * int'($signed(a)) * int'($signed(r))),
                  16'(int'($signed(a)) * int'($signed(r)) * int'($signed(r))));
        end
        1: add_req(16'($urandom), 16'($urandom), 16'($urandom));
        2: add_req(16'($urandom_range(0, 3) - 1), 16'($urandom), 16'($urandom));
        3: begin
          c = 16'($urandom_range(0, 15));
          add_req(16'($urandom), 16'($urandom), c);
        end
        default: add_req(16'($urandom_range(0, 2047) - 1024), 16'($urandom),
                         16'($urandom_range(0, 2047) - 1024));
      endcase
      if (i == 800) add_req(16'h0000, 16'h0000, 16'hFFFF);
    end
    stim_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) begin
        expected_roots.push_back(solve_roots(req_i));
      end
      if (done_o) begin
        if (expected_roots.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", result_o);
        end else begin
          if (result_o !== expected_roots[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("mismatch: expected %p, actual %p", expected_roots[0], result_o);
            end
          end
          void'(expected_roots.pop_front());
        end
      end
      idle_cycles <= ((start && !busy) || done_o) ? 0 : idle_cycles + 1;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      gap_left <= 0;
      hold_off <= 1'b0;
    end else if (start && busy) begin
    end else if (hold_off) begin
      if (expected_roots.size() == 0) hold_off <= 1'b0;
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      if (pending_reqs.size() == 900 && start) begin
        start    <= 1'b0;
        hold_off <= 1'b1;
        gap_left <= 0;
      end else if (gap_q[0] > 0 && start) begin
        start    <= 1'b0;
        gap_left <= gap_q[0] - 1;
        gap_q[0] = 0;
      end else begin
        start <= 1'b1;
        req_i <= pending_reqs.pop_front();
        void'(gap_q.pop_front());
      end
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    mismatches = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      begin
        wait (stim_done && pending_reqs.size() == 0 && !start && expected_roots.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk_i);
        if (mismatches == 0 && expected_roots.size() == 0) begin
          $display("*** PASSED ***");
        end else begin
          $display("*** FAILED ***");
        end
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("*** FAILED ***");
      end
    join_any
    $finish;
  end

endmodule
